FILE: hdl/ehe_pkg.sv
// ----------------------------------------------------------------------------
// ehe_pkg
// shared constants, codes and control structs of the histogram equalizer
// ----------------------------------------------------------------------------
package ehe_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int AREA_W     = ADDR_W + 1;

    localparam int DIM_W      = 7;
    localparam int TONE_W     = 9;
    localparam int PIX_W      = 8;
    localparam int INDEX_W    = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam int KA_W       = 8;
    localparam int KB_W       = 11;
    localparam int KC_W       = 12;
    localparam int KEY_W      = KA_W + KB_W + KC_W;

    localparam int DVD_W      = TONE_W + ADDR_W;
    localparam int DVS_W      = AREA_W;
    localparam int DIV_STEPS  = DVD_W;
    localparam int DCNT_W     = $clog2(DIV_STEPS + 1);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_TONE   = 2'd2,
        CFG_BORDER = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic load_we;
        logic capture;
        logic key_run;
        logic rank_run;
        logic div_run;
        logic out_load;
        logic out_zero;
    } t_cmd;

    typedef struct packed {
        logic in_range;
        logic key_done;
        logic rank_done;
        logic div_done;
    } t_sts;

endpackage

FILE: hdl/ehe_div.sv
// ----------------------------------------------------------------------------
// ehe_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ehe_div
    import ehe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_run,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot
);

    logic [DCNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_quo;
    logic [DVS_W:0]    trial;
    logic              fits;

    assign trial  = {r_rem, r_quo[DVD_W-1]};
    assign fits   = trial >= {1'b0, i_divisor};
    assign o_done = i_run && (r_cnt == DCNT_W'(DIV_STEPS));
    assign o_quot = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (!i_run) begin
            r_cnt <= '0;
        end else if (r_cnt != DCNT_W'(DIV_STEPS)) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_run) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_cnt != DCNT_W'(DIV_STEPS)) begin
            r_rem <= fits ? DVS_W'(trial - {1'b0, i_divisor}) : DVS_W'(trial);
            r_quo <= {r_quo[DVD_W-2:0], fits};
        end
    end

endmodule

FILE: hdl/ehe_datapath.sv
// ----------------------------------------------------------------------------
// ehe_datapath
// pixel, key and rank stores, key builder, rank counter and output divide
// ----------------------------------------------------------------------------
module ehe_datapath
    import ehe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [INDEX_W-1:0]    i_pixel_index,
    input  logic [PIX_W-1:0]      i_pixel_value,
    output logic [PIX_W-1:0]      o_value
);

    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic [TONE_W-1:0] r_tone;
    logic              r_border;

    logic [DIM_W-1:0]  eff_w;
    logic [DIM_W-1:0]  eff_h;
    logic [AREA_W-1:0] area;
    logic [COL_W-1:0]  w_last;
    logic [ROW_W-1:0]  h_last;

    logic [PIX_W-1:0]  pix_mem  [DEPTH];
    logic [KEY_W-1:0]  key_mem  [DEPTH];
    logic [ADDR_W-1:0] rank_mem [DEPTH];

    logic [COL_W-1:0]  r_kx;
    logic [ROW_W-1:0]  r_ky;
    logic [ADDR_W-1:0] r_kidx;
    logic [3:0]        r_kstep;
    logic [PIX_W-1:0]  r_pix_rd;
    logic [PIX_W-1:0]  r_ctr;
    logic [KB_W-1:0]   r_cross;
    logic [KC_W-1:0]   r_full;
    logic [PIX_W-1:0]  n_ctr;
    logic [KB_W-1:0]   n_cross;
    logic [KC_W-1:0]   n_full;
    logic [3:0]        data_k;
    logic [1:0]        ndx;
    logic [1:0]        ndy;
    logic [COL_W-1:0]  xx;
    logic [ROW_W-1:0]  yy;
    logic [AREA_W-1:0] nb_addr;
    logic              key_last;

    logic [ADDR_W-1:0] r_ri;
    logic [AREA_W-1:0] r_rj;
    logic [ADDR_W-1:0] r_cnt;
    logic [ADDR_W-1:0] n_cnt;
    logic [KEY_W-1:0]  r_keya;
    logic [KEY_W-1:0]  r_keyb;
    logic [AREA_W-1:0] jd;
    logic              less;
    logic              row_end;

    logic [INDEX_W-1:0] r_pos;
    logic [ADDR_W-1:0]  r_rank_rd;
    logic [PIX_W-1:0]   r_out;
    logic [DVD_W-1:0]   quot;
    logic               div_done;

    localparam logic [1:0] D_MINUS = 2'd0;
    localparam logic [1:0] D_ZERO  = 2'd1;
    localparam logic [1:0] D_PLUS  = 2'd2;
    localparam logic [3:0] K_LAST  = 4'd9;
    localparam logic [3:0] K_CTR   = 4'd4;

    function automatic logic [1:0] nb_dx(input logic [3:0] k);
        case (k)
            4'd0, 4'd3, 4'd6: nb_dx = D_MINUS;
            4'd1, 4'd4, 4'd7: nb_dx = D_ZERO;
            default:          nb_dx = D_PLUS;
        endcase
    endfunction

    function automatic logic [1:0] nb_dy(input logic [3:0] k);
        case (k)
            4'd0, 4'd1, 4'd2: nb_dy = D_MINUS;
            4'd3, 4'd4, 4'd5: nb_dy = D_ZERO;
            default:          nb_dy = D_PLUS;
        endcase
    endfunction

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(MAX_WIDTH);
            r_height <= DIM_W'(MAX_HEIGHT);
            r_tone   <= TONE_W'(256);
            r_border <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                CFG_TONE:   r_tone   <= i_cfg_data[TONE_W-1:0];
                CFG_BORDER: r_border <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_width == '0) begin
            eff_w = DIM_W'(1);
        end else if (r_width > DIM_W'(MAX_WIDTH)) begin
            eff_w = DIM_W'(MAX_WIDTH);
        end else begin
            eff_w = r_width;
        end
        if (r_height == '0) begin
            eff_h = DIM_W'(1);
        end else if (r_height > DIM_W'(MAX_HEIGHT)) begin
            eff_h = DIM_W'(MAX_HEIGHT);
        end else begin
            eff_h = r_height;
        end
    end

    assign area   = AREA_W'(eff_w) * AREA_W'(eff_h);
    assign w_last = COL_W'(eff_w - 1'b1);
    assign h_last = ROW_W'(eff_h - 1'b1);

    // neighbour address
    assign ndx = nb_dx(r_kstep);
    assign ndy = nb_dy(r_kstep);

    always_comb begin
        case (ndx)
            D_MINUS: xx = (r_kx == '0) ? (r_border ? w_last : '0) : r_kx - 1'b1;
            D_ZERO:  xx = r_kx;
            default: xx = (r_kx == w_last) ? (r_border ? '0 : w_last) : r_kx + 1'b1;
        endcase
        case (ndy)
            D_MINUS: yy = (r_ky == '0) ? (r_border ? h_last : '0) : r_ky - 1'b1;
            D_ZERO:  yy = r_ky;
            default: yy = (r_ky == h_last) ? (r_border ? '0 : h_last) : r_ky + 1'b1;
        endcase
    end

    assign nb_addr = AREA_W'(AREA_W'(yy) * AREA_W'(eff_w)) + AREA_W'(xx);

    // pixel store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            pix_mem[i_pixel_index[ADDR_W-1:0]] <= i_pixel_value;
        end
        r_pix_rd <= pix_mem[nb_addr[ADDR_W-1:0]];
    end

    // key build, data of neighbour k arrives at step k+1
    assign data_k   = r_kstep - 1'b1;
    assign key_last = (r_kstep == K_LAST);

    always_comb begin
        n_full  = ((r_kstep == 4'd1) ? '0 : r_full) + KC_W'(r_pix_rd);
        n_cross = (r_kstep == 4'd1) ? '0 : r_cross;
        if (nb_dx(data_k) == D_ZERO || nb_dy(data_k) == D_ZERO) begin
            n_cross = n_cross + KB_W'(r_pix_rd);
        end
        n_ctr = (data_k == K_CTR) ? r_pix_rd : r_ctr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || !i_cmd.key_run) begin
            r_kx    <= '0;
            r_ky    <= '0;
            r_kidx  <= '0;
            r_kstep <= '0;
        end else if (key_last) begin
            r_kstep <= '0;
            r_kidx  <= r_kidx + 1'b1;
            if (r_kx == w_last) begin
                r_kx <= '0;
                r_ky <= r_ky + 1'b1;
            end else begin
                r_kx <= r_kx + 1'b1;
            end
        end else begin
            r_kstep <= r_kstep + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_full  <= n_full;
        r_cross <= n_cross;
        r_ctr   <= n_ctr;
        if (i_cmd.key_run && key_last) begin
            key_mem[r_kidx] <= {n_ctr,
                                KB_W'(n_cross + KB_W'(n_ctr)),
                                KC_W'(n_full + KC_W'(n_ctr))};
        end
        r_keya <= key_mem[r_ri];
        r_keyb <= key_mem[r_rj[ADDR_W-1:0]];
    end

    // rank count: pixels ordered before pixel ri
    assign jd      = r_rj - 1'b1;
    assign less    = (r_keyb < r_keya) || ((r_keyb == r_keya) && (jd < AREA_W'(r_ri)));
    assign n_cnt   = (r_rj != '0 && less) ? r_cnt + 1'b1 : r_cnt;
    assign row_end = (r_rj == area);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || !i_cmd.rank_run) begin
            r_ri  <= '0;
            r_rj  <= '0;
            r_cnt <= '0;
        end else if (row_end) begin
            r_ri  <= r_ri + 1'b1;
            r_rj  <= '0;
            r_cnt <= '0;
        end else begin
            r_rj  <= r_rj + 1'b1;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rank_run && row_end) begin
            rank_mem[r_ri] <= n_cnt;
        end
        r_rank_rd <= rank_mem[r_pos[ADDR_W-1:0]];
    end

    // output scaling
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pos <= i_pixel_index;
        end
        if (i_cmd.out_load) begin
            if (i_cmd.out_zero) begin
                r_out <= '0;
            end else if (quot[DVD_W-1:PIX_W] != '0) begin
                r_out <= '1;
            end else begin
                r_out <= quot[PIX_W-1:0];
            end
        end
    end

    ehe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_run      (i_cmd.div_run),
        .i_dividend (DVD_W'(r_tone) * DVD_W'(r_rank_rd)),
        .i_divisor  (area),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    assign o_value         = r_out;
    assign o_sts.in_range  = AREA_W'(i_pixel_index) < area;
    assign o_sts.key_done  = i_cmd.key_run && key_last && (AREA_W'(r_kidx) == area - 1'b1);
    assign o_sts.rank_done = i_cmd.rank_run && row_end && (AREA_W'(r_ri) == area - 1'b1);
    assign o_sts.div_done  = div_done;

endmodule

FILE: hdl/ehe_ctrl.sv
// ----------------------------------------------------------------------------
// ehe_ctrl
// sequencer for loads, ranking, rank lookup and output word handoff
// ----------------------------------------------------------------------------
module ehe_ctrl
    import ehe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_kind,
    input  logic i_cfg_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY,
        S_RANK,
        S_RD1,
        S_RD2,
        S_DIV,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ranks_valid;
    logic   r_zero;
    logic   r_out_valid;
    logic   accept;
    logic   out_free;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_in_kind == KIND_READ) begin
                    if (!i_sts.in_range) begin
                        n_state = S_FIN;
                    end else if (r_ranks_valid) begin
                        n_state = S_RD1;
                    end else begin
                        n_state = S_KEY;
                    end
                end
            end
            S_KEY:   if (i_sts.key_done) n_state = S_RANK;
            S_RANK:  if (i_sts.rank_done) n_state = S_RD1;
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_DIV;
            S_DIV:   if (i_sts.div_done) n_state = S_FIN;
            S_FIN:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.load_we  = accept && i_in_kind == KIND_LOAD && i_sts.in_range;
        o_cmd.capture  = accept;
        o_cmd.key_run  = (r_state == S_KEY);
        o_cmd.rank_run = (r_state == S_RANK);
        o_cmd.div_run  = (r_state == S_DIV) || (r_state == S_FIN);
        o_cmd.out_load = (r_state == S_FIN) && out_free;
        o_cmd.out_zero = r_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ranks_valid <= 1'b0;
            r_zero        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid || o_cmd.load_we) begin
                r_ranks_valid <= 1'b0;
            end else if (i_sts.rank_done) begin
                r_ranks_valid <= 1'b1;
            end
            if (accept) begin
                r_zero <= !i_sts.in_range;
            end
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: hdl/exact_histogram_equalizer_top.sv
// load word: accepted without stalling the input, no result word
// read word with ranks current: result through rank lookup and the 21-step divider
// first read after a load or register write first rebuilds keys and ranks for N = width*height,
// using the key builder (one pixel port) and the rank count (one key compare per cycle)
// synchronous active-low reset clears control state; stores are undefined until written
// ----------------------------------------------------------------------------
// exact_histogram_equalizer_top
// exact histogram equalization with neighborhood ordering of a grey image
// ----------------------------------------------------------------------------
module exact_histogram_equalizer_top
    import ehe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_in_kind,
    input  logic [INDEX_W-1:0]    i_in_pixel_index,
    input  logic [PIX_W-1:0]      i_in_pixel_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PIX_W-1:0]      o_out_equalized_value,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    ehe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_kind   (i_in_kind),
        .i_cfg_valid (i_cfg_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    ehe_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_pixel_index (i_in_pixel_index),
        .i_pixel_value (i_in_pixel_value),
        .o_value       (o_out_equalized_value)
    );

endmodule

FILE: hdl/ehe_checker.sv
// ----------------------------------------------------------------------------
// ehe_checker
// port-level checks of the histogram equalizer
// ----------------------------------------------------------------------------
module ehe_checker
    import ehe_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  i_in_kind,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [PIX_W-1:0]      o_out_equalized_value
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_equalized_value))
        else $error("output word changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("bad state after reset");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_kind == KIND_READ |=> !o_in_ready)
        else $error("read word did not occupy the block");

    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_kind == KIND_LOAD |=> o_in_ready)
        else $error("load word stalled the input");

endmodule

bind exact_histogram_equalizer_top ehe_checker u_chk (.*);
